// ===== hw/rtl/mdp_pkg.sv =====
// ----------------------------------------------------------------------------
// mdp_pkg: shared types and constants for the modular dot product
// Widths of element and accumulator words, and the queue status group.
// ----------------------------------------------------------------------------
`default_nettype none

package mdp_pkg;

   localparam int ELEM_W = 32;
   localparam int ACC_W  = 64;
   localparam int CNT_W  = $clog2(ACC_W);

   typedef logic [ELEM_W-1:0] elem_type;
   typedef logic [ACC_W-1:0]  acc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mdp_front.sv =====
// ----------------------------------------------------------------------------
// mdp_front: element intake and multiply-accumulate
// Registers each product, adds it into the wrapping accumulator and pushes
// the finished sum of a vector into the queue as the last product leaves its register.
// ----------------------------------------------------------------------------
`default_nettype none

module mdp_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire mdp_pkg::elem_type   elem_a,
   input  wire mdp_pkg::elem_type   elem_b,
   input  wire logic                req_tlast,
   input  wire mdp_pkg::q_stat_type q_stat,
   output logic                     push,
   output mdp_pkg::acc_type         push_data
);

   logic             s1_valid_ff;
   logic             s1_last_ff;
   mdp_pkg::acc_type s1_prod_ff;
   mdp_pkg::acc_type acc_ff;
   mdp_pkg::acc_type acc_in;
   mdp_pkg::acc_type sum;
   logic             s1_advance;

   assign sum        = acc_ff + s1_prod_ff;
   assign s1_advance = s1_valid_ff && (!s1_last_ff || !q_stat.full);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign push       = s1_valid_ff && s1_last_ff && !q_stat.full;
   assign push_data  = sum;
   assign acc_in     = s1_last_ff ? '0 : sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s1_advance) begin
            acc_ff <= acc_in;
         end
      end
      if (req_tvalid && req_tready) begin
         s1_prod_ff <= mdp_pkg::ACC_W'(elem_a) * mdp_pkg::ACC_W'(elem_b);
         s1_last_ff <= req_tlast;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mdp_queue.sv =====
// ----------------------------------------------------------------------------
// mdp_queue: short queue of finished vector sums
// First-word-fall-through register queue between intake and reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module mdp_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire mdp_pkg::acc_type    push_data,
   input  wire logic                pop,
   output mdp_pkg::acc_type         pop_data,
   output mdp_pkg::q_stat_type      q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mdp_pkg::acc_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push;
   logic              do_pop;

   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mdp_back.sv =====
// ----------------------------------------------------------------------------
// mdp_back: modular reduction and result register
// Bit-serial restoring remainder, one dividend bit per cycle, then a
// result register toward the output channel. A zero modulus skips the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module mdp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mdp_pkg::q_stat_type q_stat,
   input  wire mdp_pkg::acc_type    pop_data,
   output logic                     pop,
   input  wire mdp_pkg::acc_type    modulus,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output mdp_pkg::acc_type         rsp_tdata
);

   typedef enum logic [1:0] {
      IDLE,
      RUN,
      HOLD
   } state_type;

   state_type                state_ff;
   mdp_pkg::acc_type         div_ff;
   mdp_pkg::acc_type         rem_ff;
   mdp_pkg::acc_type         rem_in;
   mdp_pkg::acc_type         n_ff;
   logic [mdp_pkg::CNT_W-1:0] cnt_ff;
   logic                     out_valid_ff;
   mdp_pkg::acc_type         out_data_ff;
   logic [mdp_pkg::ACC_W:0]  trial;
   logic                     out_free;

   assign pop        = (state_ff == IDLE) && !q_stat.empty;
   assign trial      = {rem_ff, div_ff[mdp_pkg::ACC_W-1]};
   assign rem_in     = (trial >= {1'b0, n_ff}) ?
                       mdp_pkg::ACC_W'(trial - {1'b0, n_ff}) : trial[mdp_pkg::ACC_W-1:0];
   assign out_free   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == HOLD) && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (pop) begin
                  div_ff <= pop_data;
                  n_ff   <= modulus;
                  cnt_ff <= '0;
                  if (modulus == '0) begin
                     rem_ff   <= pop_data;
                     state_ff <= HOLD;
                  end else begin
                     rem_ff   <= '0;
                     state_ff <= RUN;
                  end
               end
            end
            RUN: begin
               rem_ff <= rem_in;
               div_ff <= {div_ff[mdp_pkg::ACC_W-2:0], 1'b0};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == '1) begin
                  state_ff <= HOLD;
               end
            end
            HOLD: begin
               if (out_free) begin
                  out_data_ff  <= rem_ff;
                  state_ff     <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/modular_dot_product_top.sv =====
// ----------------------------------------------------------------------------
// modular_dot_product_top: streaming dot product reduced modulo n
// Usage:
//   req_* carries one element pair per transfer; req_tlast marks the final
//   pair of a vector. rsp_* gives one 64-bit remainder per vector.
//   csr_wen/csr_wdata write the modulus; write it only while idle.
//   Intake takes one pair per cycle unless a last pair waits on a full
//   queue: a 32x32 multiply stage feeds the 64-bit wrapping accumulator.
//   The sum of a vector enters a short queue; the reduction unit takes one
//   dividend bit per cycle and takes no new sum from the queue until its
//   result has moved into the result register.
//   A zero modulus skips the reduction and returns the raw sum.
//   When rsp_tready is low the result register holds; the queue absorbs
//   further sums, and once it fills req_tready drops on a last transfer.
//   Reset clears the accumulator, the queue and the output, and sets the
//   modulus to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_dot_product_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [31:0] elem_a, [63:32] elem_b
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [63:0] dot_mod
   input  wire logic        csr_wen,
   input  wire logic [63:0] csr_wdata
);

   mdp_pkg::acc_type    modulus_ff;
   mdp_pkg::q_stat_type q_stat;
   mdp_pkg::acc_type    push_data;
   mdp_pkg::acc_type    pop_data;
   logic                push;
   logic                pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= mdp_pkg::acc_type'(1);
      end else if (csr_wen) begin
         modulus_ff <= csr_wdata;
      end
   end

   mdp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .elem_a     (req_tdata[31:0]),
      .elem_b     (req_tdata[63:32]),
      .req_tlast  (req_tlast),
      .q_stat     (q_stat),
      .push       (push),
      .push_data  (push_data)
   );

   mdp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   mdp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .pop_data   (pop_data),
      .pop        (pop),
      .modulus    (modulus_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/mdp_checker.sv =====
// ----------------------------------------------------------------------------
// mdp_checker: port-level checks for the modular dot product
// Tracks the modulus and outstanding vectors from the ports alone.
// ----------------------------------------------------------------------------
`default_nettype none

module mdp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic        csr_wen,
   input wire logic [63:0] csr_wdata
);

   logic [63:0] mod_ff;
   logic [7:0]  pending_ff;
   logic        last_xfer;
   logic        rsp_xfer;

   assign last_xfer = req_tvalid && req_tready && req_tlast;
   assign rsp_xfer  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff     <= 64'd1;
         pending_ff <= '0;
      end else begin
         if (csr_wen) begin
            mod_ff <= csr_wdata;
         end
         if (last_xfer && !rsp_xfer) begin
            pending_ff <= pending_ff + 1'b1;
         end else if (rsp_xfer && !last_xfer) begin
            pending_ff <= pending_ff - 1'b1;
         end
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_rsp_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && mod_ff != 64'd0 |-> rsp_tdata < mod_ff)
      else $error("result not below modulus");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 8'd0)
      else $error("result without a finished vector");

endmodule

bind modular_dot_product_top mdp_checker u_mdp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_wen    (csr_wen),
   .csr_wdata  (csr_wdata)
);

`default_nettype wire
